@@ hw/rtl/rppg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_pkg
// Shared types, register codes and constant tables of the ring plasma pixel
// generator.
// ----------------------------------------------------------------------------
package rppg_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_RATE_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RING_RATE_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_RATE_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RING_RATE_D = 3'd4;

	// input op codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	// plasma modes
	localparam logic MODE_SINGLE = 1'b0;
	localparam logic MODE_RING   = 1'b1;

	// field widths
	localparam int COORD_W = 4;
	localparam int FTIME_W = 16;
	localparam int VALUE_W = 8;
	localparam int RATE_W  = 8;

	// phase store: 8.16 phases, four lanes per entry
	localparam int NUM_RINGS     = 4;
	localparam int PHASE_W       = 24;
	localparam int PHASE_INT_LSB = 16;
	localparam int PHASE_ENTRY_W = NUM_RINGS * PHASE_W;
	localparam int PHASE_DEPTH   = 2;

	localparam logic [RATE_W-1:0] SINGLE_RATE = 8'd50;

	// lane k at bits [24k +: 24]; integer parts 0, 1, 4, 3
	localparam logic [PHASE_ENTRY_W-1:0] RING_PHASE_INIT =
		{24'h030000, 24'h040000, 24'h010000, 24'h000000};

	localparam logic [7:0] RING_OFF_X [NUM_RINGS] = '{8'd6, 8'd13, 8'd17, 8'd31};
	localparam logic [7:0] RING_OFF_Y [NUM_RINGS] = '{8'd10, 8'd3, 8'd1, 8'd22};

	// sine table: three periods over 256 entries (period of 85)
	localparam int WAVE_PERIOD = 85;
	localparam int HALF_LEN    = 43;

	localparam logic signed [7:0] HALF_WAVE [HALF_LEN] = '{
		8'sd0, 8'sd9, 8'sd18, 8'sd28, 8'sd37, 8'sd46, 8'sd54, 8'sd63,
		8'sd71, 8'sd79, 8'sd86, 8'sd92, 8'sd99, 8'sd104, 8'sd110, 8'sd114,
		8'sd118, 8'sd121, 8'sd124, 8'sd126, 8'sd127, 8'sd127, 8'sd127, 8'sd126,
		8'sd125, 8'sd123, 8'sd120, 8'sd116, 8'sd112, 8'sd107, 8'sd102, 8'sd96,
		8'sd89, 8'sd82, 8'sd75, 8'sd67, 8'sd59, 8'sd50, 8'sd41, 8'sd32,
		8'sd23, 8'sd14, 8'sd4
	};

	typedef logic signed [7:0] sine_tab_t [256];

	// second half of each period mirrors the first with sign
	function automatic sine_tab_t build_sine();
		sine_tab_t t;
		int        i;
		int        p;
		p = 0;
		for (i = 0; i < 256; i++) begin
			if (p < HALF_LEN) begin
				t[i] = HALF_WAVE[p];
			end else begin
				t[i] = -HALF_WAVE[WAVE_PERIOD - p];
			end
			p = (p == WAVE_PERIOD - 1) ? 0 : p + 1;
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

	// per-lane sine table index
	typedef logic [NUM_RINGS-1:0][7:0] lane_idx_t;

	// distance store fill sequencer status
	typedef struct packed {
		logic busy;
		logic we;
	} fill_ctrl_t;

endpackage

@@ hw/rtl/rppg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rppg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/rppg_init.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_init
// Post-reset fill sequencer: walks every grid cell once and produces the
// scaled squared distance from the grid center for the distance stores.
// ----------------------------------------------------------------------------
module rppg_init import rppg_pkg::*; #(
	parameter int GRID_SIZE = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	output fill_ctrl_t                         ctrl,
	output logic [2*$clog2(GRID_SIZE)-1:0]     addr,
	output logic [7:0]                         cell_dist
);

	localparam int LG    = $clog2(GRID_SIZE);
	localparam int AW    = 2 * LG;
	// dmax = GRID_SIZE^2 / 2, so scaling by 255/dmax is a shift
	localparam int SHIFT = 2 * LG - 1;
	localparam logic [LG-1:0] HALF_C = LG'(GRID_SIZE / 2);

	logic [AW-1:0] addr_q;
	logic          busy_q;
	logic [LG-1:0] x, y, dx, dy;
	logic [AW-1:0] dx2, dy2;
	logic [AW:0]   d;
	logic [AW+8:0] scaled;

	// cell sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			addr_q <= addr_q + 1'b1;
			if (&addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	// distance of the current cell
	always_comb begin
		x      = addr_q[LG-1:0];
		y      = addr_q[AW-1:LG];
		dx     = (x >= HALF_C) ? x - HALF_C : HALF_C - x;
		dy     = (y >= HALF_C) ? y - HALF_C : HALF_C - y;
		dx2    = {{LG{1'b0}}, dx} * {{LG{1'b0}}, dx};
		dy2    = {{LG{1'b0}}, dy} * {{LG{1'b0}}, dy};
		d      = {1'b0, dx2} + {1'b0, dy2};
		// 255 * d
		scaled = {d, 8'b0} - {8'b0, d};
	end

	assign ctrl.busy = busy_q;
	assign ctrl.we   = busy_q;
	assign addr      = addr_q;
	assign cell_dist = scaled[SHIFT +: 8];

endmodule

@@ hw/rtl/rppg_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppg_out
// Sine lookup and lane sum for a pixel, followed by the output register.
// ----------------------------------------------------------------------------
module rppg_out import rppg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       mode,
	input  lane_idx_t                  idx,
	output logic                       room,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [VALUE_W-1:0]  pixel_value
);

	logic signed [7:0]         sine [NUM_RINGS];
	logic signed [9:0]         sum;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;

	// four table reads and their sum; floor divide by four is bits 9..2
	always_comb begin
		sum = '0;
		for (int k = 0; k < NUM_RINGS; k++) begin
			sine[k] = SINE_TAB[idx[k]];
			sum     = sum + {{2{sine[k][7]}}, sine[k]};
		end
		value = (mode == MODE_RING) ? sum[9:2] : sine[0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value;
		end
	end

	assign room        = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign pixel_value = value_q;

endmodule

@@ hw/rtl/ring_plasma_pixel_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_plasma_pixel_generator
// Sine plasma pixel source over a square power-of-two grid, single radial or
// four-ring mode, with frame-time phase advance.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_stall is low, pixel requests and
// frame advances mixed in any order; a pixel result is registered in stage 1
// and again in the output register; frame advances give no result. Phases
// live in a two-entry synchronous memory (single phase, four ring phases)
// read at acceptance and written back in the cycle after, with the written
// value forwarded to a directly following transaction. Four copies of the
// distance table serve the four ring lookups of a pixel in the same cycle.
// After reset a sweep over the GRID_SIZE*GRID_SIZE cells fills the distance
// tables, during which in_stall is held high; configuration writes are taken
// at any time and must only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module ring_plasma_pixel_generator import rppg_pkg::*; #(
	parameter int GRID_SIZE = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [COORD_W-1:0]         col,
	input  logic [COORD_W-1:0]         row,
	input  logic [FTIME_W-1:0]         frame_time,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [VALUE_W-1:0]  pixel_value,
	// configuration channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int LG = $clog2(GRID_SIZE);
	localparam int AW = 2 * LG;

	// config registers
	logic                                mode_q;
	logic [NUM_RINGS-1:0][RATE_W-1:0]    rate_q;

	// fill sequencer
	fill_ctrl_t                          fill;
	logic [AW-1:0]                       fill_addr;
	logic [7:0]                          fill_dist;

	// stage 0
	logic                                accept;
	logic [LG-1:0]                       cx, cy, cxm;
	logic [NUM_RINGS-1:0][LG-1:0]        ring_x, ring_y;
	logic [NUM_RINGS-1:0][AW-1:0]        dist_raddr;
	logic [NUM_RINGS-1:0][RATE_W-1:0]    rate_sel;
	logic [NUM_RINGS-1:0][PHASE_W-1:0]   prod;

	// stage 1
	logic                                v_s1;
	logic                                fwd_s1;
	logic                                frame_s1;
	logic [NUM_RINGS-1:0][PHASE_W-1:0]   prod_s1;
	logic [NUM_RINGS-1:0][7:0]           dist_rdata;
	logic [PHASE_ENTRY_W-1:0]            ph_rdata;
	logic [PHASE_ENTRY_W-1:0]            phase_cur;
	logic [PHASE_ENTRY_W-1:0]            phase_new;
	logic [PHASE_ENTRY_W-1:0]            wr_q;
	lane_idx_t                           idx_s1;
	logic                                upd_we;
	logic                                pix_go;
	logic                                en1;
	logic                                room;

	// phase memory write port
	logic                                ph_we;
	logic                                ph_waddr;
	logic [PHASE_ENTRY_W-1:0]            ph_wdata;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
			rate_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:        mode_q    <= cfg_data[0];
				REG_RING_RATE_A: rate_q[0] <= cfg_data;
				REG_RING_RATE_B: rate_q[1] <= cfg_data;
				REG_RING_RATE_C: rate_q[2] <= cfg_data;
				REG_RING_RATE_D: rate_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	rppg_init #(.GRID_SIZE(GRID_SIZE)) u_init (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fill),
		.addr      (fill_addr),
		.cell_dist (fill_dist)
	);

	// stage 0: handshake
	assign in_stall = fill.busy || (v_s1 && !en1);
	assign accept   = in_valid && !in_stall;

	// grid coordinates, low bits kept, or zero-extended for a wider grid
	generate
		if (LG <= COORD_W) begin : g_coord_trunc
			assign cx = col[LG-1:0];
			assign cy = row[LG-1:0];
		end else begin : g_coord_ext
			assign cx = {{(LG-COORD_W){1'b0}}, col};
			assign cy = {{(LG-COORD_W){1'b0}}, row};
		end
	endgenerate

	// mirrored column
	assign cxm = ~cx;

	// distance addresses and phase products
	always_comb begin
		rate_sel = (mode_q == MODE_RING) ? rate_q : {24'h0, SINGLE_RATE};
		for (int k = 0; k < NUM_RINGS; k++) begin
			ring_x[k]     = cxm + RING_OFF_X[k][LG-1:0];
			ring_y[k]     = cy + RING_OFF_Y[k][LG-1:0];
			dist_raddr[k] = {ring_y[k], ring_x[k]};
			prod[k]       = {16'b0, rate_sel[k]} * {8'b0, frame_time};
		end
		if (mode_q == MODE_SINGLE) begin
			dist_raddr[0] = {cy, cx};
		end
	end

	// distance tables, one copy per lane
	generate
		for (genvar k = 0; k < NUM_RINGS; k++) begin : g_dist
			rppg_ram #(.WIDTH(8), .DEPTH(GRID_SIZE * GRID_SIZE)) u_dist_ram (
				.clk   (clk),
				.we    (fill.we),
				.waddr (fill_addr),
				.wdata (fill_dist),
				.re    (accept),
				.raddr (dist_raddr[k]),
				.rdata (dist_rdata[k])
			);
		end
	endgenerate

	// phase memory: entry 0 single phase, entry 1 ring phases
	always_comb begin
		if (fill.we) begin
			ph_we    = (fill_addr[AW-1:1] == '0);
			ph_waddr = fill_addr[0];
			ph_wdata = fill_addr[0] ? RING_PHASE_INIT : '0;
		end else begin
			ph_we    = upd_we;
			ph_waddr = mode_q;
			ph_wdata = phase_new;
		end
	end

	rppg_ram #(.WIDTH(PHASE_ENTRY_W), .DEPTH(PHASE_DEPTH)) u_phase_ram (
		.clk   (clk),
		.we    (ph_we),
		.waddr (ph_waddr),
		.wdata (ph_wdata),
		.re    (accept),
		.raddr (mode_q),
		.rdata (ph_rdata)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en1) begin
			v_s1   <= accept;
			fwd_s1 <= accept && upd_we;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= op;
			prod_s1  <= prod;
		end
		if (upd_we) begin
			wr_q <= phase_new;
		end
	end

	// stage 1: forward, update, sine indices
	assign en1    = !v_s1 || (frame_s1 == OP_FRAME) || room;
	assign upd_we = v_s1 && (frame_s1 == OP_FRAME);
	assign pix_go = v_s1 && (frame_s1 == OP_PIXEL) && room;

	always_comb begin
		phase_cur = fwd_s1 ? wr_q : ph_rdata;
		for (int k = 0; k < NUM_RINGS; k++) begin
			phase_new[k*PHASE_W +: PHASE_W] = phase_cur[k*PHASE_W +: PHASE_W] + prod_s1[k];
			idx_s1[k] = dist_rdata[k] + phase_cur[k*PHASE_W + PHASE_INT_LSB +: 8];
		end
	end

	rppg_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (pix_go),
		.mode        (mode_q),
		.idx         (idx_s1),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_value (pixel_value)
	);

	// no transaction while the tables are being filled
	a_fill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		fill.busy |-> in_stall)
		else $error("input accepted during table fill");

	// fill writes and phase updates never collide
	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill.we && upd_we))
		else $error("phase write collision");

	// forwarding only applies to a live stage 1 transaction
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forward flag without transaction");

	// an accepted transaction always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted transaction lost");

endmodule
